/* src/crcdf_pkg.sv */
package crcdf_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0]  START_MARKER_RESET = 8'd165;
    localparam logic [15:0] MAX_LENGTH_RESET   = 16'd1024;

    localparam logic        CFG_START_MARKER = 1'b0;
    localparam logic        CFG_MAX_LENGTH   = 1'b1;

    localparam logic [1:0]  ST_INCOMPLETE = 2'd0;
    localparam logic [1:0]  ST_COMPLETE   = 2'd1;
    localparam logic [1:0]  ST_ERROR      = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_command;
        logic [15:0] frame_length;
    } crcdf_result_t;

    function automatic logic [31:0] crc32_add_byte(input logic [31:0] crc,
                                                   input logic [7:0]  data);
        logic [31:0] c;
        c = ~crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return ~c;
    endfunction

endpackage

/* src/crcdf_parser.sv */
module crcdf_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             data_byte,
    input  logic [7:0]             start_marker,
    input  logic [15:0]            max_payload_length,
    output crcdf_pkg::crcdf_result_t result
);
    import crcdf_pkg::*;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC     = 3'd4;
    localparam logic [2:0] CRC_BYTES  = 3'd4;

    logic [2:0]  phase_reg,    phase_next;
    logic [15:0] position_reg, position_next;
    logic [15:0] length_reg,   length_next;
    logic [7:0]  command_reg,  command_next;
    logic [31:0] crc_acc_reg,  crc_acc_next;
    logic [31:0] crc_rx_reg,   crc_rx_next;

    logic [31:0] crc_updated;
    logic [15:0] position_inc;
    logic [15:0] length_full;
    logic [31:0] crc_rx_merged;
    logic [1:0]  status;
    logic        pvalid;
    logic [15:0] pindex;

    assign crc_updated  = crc32_add_byte(crc_acc_reg, data_byte);
    assign position_inc = position_reg + 16'd1;
    assign length_full  = {data_byte, length_reg[7:0]};

    always_comb
    begin
        crc_rx_merged = crc_rx_reg;
        unique case (position_reg[1:0])
            2'd0: crc_rx_merged[7:0]   = crc_rx_reg[7:0]   | data_byte;
            2'd1: crc_rx_merged[15:8]  = crc_rx_reg[15:8]  | data_byte;
            2'd2: crc_rx_merged[23:16] = crc_rx_reg[23:16] | data_byte;
            2'd3: crc_rx_merged[31:24] = crc_rx_reg[31:24] | data_byte;
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        length_next   = length_reg;
        command_next  = command_reg;
        crc_acc_next  = crc_acc_reg;
        crc_rx_next   = crc_rx_reg;
        status        = ST_INCOMPLETE;
        pvalid        = 1'b0;
        pindex        = 16'd0;

        unique case (phase_reg)
            PH_CMD:
            begin
                command_next = data_byte;
                crc_acc_next = crc_updated;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                crc_acc_next = crc_updated;
                if (position_reg == 16'd0)
                begin
                    length_next   = {8'd0, data_byte};
                    position_next = 16'd1;
                end
                else if (length_full > max_payload_length)
                begin
                    phase_next    = PH_HUNT;
                    position_next = 16'd0;
                    length_next   = 16'd0;
                    crc_acc_next  = 32'd0;
                    crc_rx_next   = 32'd0;
                    status        = ST_ERROR;
                end
                else
                begin
                    length_next   = length_full;
                    position_next = 16'd0;
                    phase_next    = (length_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                crc_acc_next  = crc_updated;
                pvalid        = 1'b1;
                pindex        = position_reg;
                position_next = position_inc;
                if (position_inc == length_reg)
                begin
                    phase_next    = PH_CRC;
                    position_next = 16'd0;
                end
            end
            PH_CRC:
            begin
                crc_rx_next   = crc_rx_merged;
                position_next = position_inc;
                if (position_inc >= {13'd0, CRC_BYTES})
                begin
                    if (crc_acc_reg == crc_rx_merged)
                    begin
                        phase_next    = PH_HUNT;
                        position_next = 16'd0;
                        status        = ST_COMPLETE;
                    end
                    else
                    begin
                        phase_next    = PH_HUNT;
                        position_next = 16'd0;
                        length_next   = 16'd0;
                        crc_acc_next  = 32'd0;
                        crc_rx_next   = 32'd0;
                        status        = ST_ERROR;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (data_byte == start_marker)
                begin
                    phase_next    = PH_CMD;
                    position_next = 16'd0;
                    length_next   = 16'd0;
                    crc_acc_next  = 32'd0;
                    crc_rx_next   = 32'd0;
                end
            end
        endcase
    end

    always_comb
    begin
        result.status        = status;
        result.payload_valid = pvalid;
        result.payload_byte  = pvalid ? data_byte : 8'd0;
        result.payload_index = pindex;
        result.frame_command = command_next;
        result.frame_length  = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            position_reg <= 16'd0;
            length_reg   <= 16'd0;
            command_reg  <= 8'd0;
            crc_acc_reg  <= 32'd0;
            crc_rx_reg   <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            length_reg   <= length_next;
            command_reg  <= command_next;
            crc_acc_reg  <= crc_acc_next;
            crc_rx_reg   <= crc_rx_next;
        end
    end

endmodule

/* src/crc32_frame_deframer.sv */
// A request accepted into the input register is parsed into the result register,
// which offers it until out_ready takes it. Throughput: one byte per cycle unless
// a result waits on out_ready; each byte is parsed and its CRC-32 folded in
// by combinational logic between the input register and the result register.
// While a result waits, the input register can still take one more byte.
// Reset (rst_n, asynchronous): back to hunting, frame state and CRC cleared,
// start_marker = 165 and max_payload_length = 1024.
module crc32_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [7:0]  frame_command,
    output logic [15:0] frame_length
);
    import crcdf_pkg::*;

    logic [7:0]    start_marker_reg;
    logic [15:0]   max_length_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    crcdf_result_t result_reg;
    crcdf_result_t result_next;
    logic          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data[7:0];
                CFG_MAX_LENGTH:   max_length_reg   <= cfg_data;
            endcase
        end
    end

    // hold the request until the parser takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    crcdf_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (advance),
        .data_byte          (in_byte_reg),
        .start_marker       (start_marker_reg),
        .max_payload_length (max_length_reg),
        .result             (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign payload_valid = result_reg.payload_valid;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_index = result_reg.payload_index;
    assign frame_command = result_reg.frame_command;
    assign frame_length  = result_reg.frame_length;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while a stage is free");

    a_payload_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_valid) |-> (status == ST_INCOMPLETE))
        else $error("payload byte carries a final status");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_valid) |-> (payload_index < frame_length))
        else $error("payload index beyond frame length");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_INCOMPLETE || status == ST_COMPLETE ||
                       status == ST_ERROR))
        else $error("undefined status code");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("parsed request produced no result");
`endif

endmodule
